// ===== rtl/kmsc_pkg.sv =====
// Shared types, codes and key map tables for the keypad matrix scanner.
package kmsc_pkg;

  localparam int NUM_MAPPED = 9;
  localparam int POS_W      = 4;

  localparam logic       OP_SAMPLE = 1'b0;
  localparam logic       OP_START  = 1'b1;

  localparam logic [1:0] KIND_EVENT    = 2'd0;
  localparam logic [1:0] KIND_STEP     = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;

  localparam logic [7:0] DRIVE_FIRST = 8'hfe;
  localparam logic [7:0] DRIVE_IDLE  = 8'h00;
  localparam logic [1:0] LAST_COLUMN = 2'd3;

  typedef struct packed {
    logic       op;
    logic [3:0] row_lines;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] matrix_index;
    logic [2:0] key_id;
    logic       pressed;
    logic [7:0] column_drive;
    logic       all_released;
    logic       last;
  } out_req_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic        scan_end;
    logic [7:0]  drive;
    logic [15:0] changed;
    logic [15:0] keys;
  } cmd_t;

  // Matrix bit position of each mapped key, in ascending bit order.
  function automatic logic [3:0] map_index(input logic [POS_W-1:0] pos);
    logic [3:0] idx;
    unique case (pos)
      4'd0:    idx = 4'd0;
      4'd1:    idx = 4'd3;
      4'd2:    idx = 4'd5;
      4'd3:    idx = 4'd6;
      4'd4:    idx = 4'd8;
      4'd5:    idx = 4'd9;
      4'd6:    idx = 4'd10;
      4'd7:    idx = 4'd14;
      4'd8:    idx = 4'd15;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

  // Dense key id of each mapped key.
  function automatic logic [2:0] map_key(input logic [POS_W-1:0] pos);
    logic [2:0] key;
    unique case (pos)
      4'd0:    key = 3'd0;
      4'd1:    key = 3'd4;
      4'd2:    key = 3'd1;
      4'd3:    key = 3'd6;
      4'd4:    key = 3'd2;
      4'd5:    key = 3'd6;
      4'd6:    key = 3'd3;
      4'd7:    key = 3'd7;
      4'd8:    key = 3'd5;
      default: key = 3'd0;
    endcase
    return key;
  endfunction

endpackage

// ===== rtl/kmsc_front.sv =====
// Front end: accepts requests, tracks the scan state and queues work.
module kmsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  kmsc_pkg::in_req_t in_req,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output kmsc_pkg::cmd_t    q_push_data
);

  logic [1:0]  col_r, col_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] merged;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    merged = accum_r;
    merged[{col_r, 2'b00} +: 4] = ~in_req.row_lines;
  end

  always_comb begin
    col_nxt     = col_r;
    accum_nxt   = accum_r;
    prev_nxt    = prev_r;
    q_push_data = '0;
    if (accept) begin
      if (in_req.op == kmsc_pkg::OP_START) begin
        col_nxt           = '0;
        accum_nxt         = '0;
        prev_nxt          = '0;
        q_push_data.drive = kmsc_pkg::DRIVE_FIRST;
      end else if (col_r != kmsc_pkg::LAST_COLUMN) begin
        col_nxt           = col_r + 2'd1;
        accum_nxt         = merged;
        q_push_data.drive = ~(8'd1 << (col_r + 2'd1));
      end else begin
        col_nxt              = '0;
        accum_nxt            = merged;
        prev_nxt             = merged;
        q_push_data.scan_end = 1'b1;
        q_push_data.drive    = kmsc_pkg::DRIVE_IDLE;
        q_push_data.changed  = prev_r ^ merged;
        q_push_data.keys     = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      accum_r <= '0;
      prev_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      accum_r <= accum_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== rtl/kmsc_queue.sv =====
// Short first-in first-out queue of work between front and back ends.
module kmsc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kmsc_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output kmsc_pkg::cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kmsc_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

  overflow_a: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  underflow_a: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  count_a: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/kmsc_back.sv =====
// Back end: turns queued work into result requests through an output register.
module kmsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  kmsc_pkg::cmd_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output kmsc_pkg::out_req_t out_req
);

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_SCAN} state_t;

  state_t                       state_r, state_nxt;
  kmsc_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [kmsc_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  kmsc_pkg::out_req_t           out_req_r, out_req_nxt;
  logic                         out_free;
  logic [3:0]                   bit_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign bit_idx   = kmsc_pkg::map_index(pos_r);
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          pos_nxt   = '0;
          state_nxt = q_data.scan_end ? ST_SCAN : ST_STEP;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_req_nxt              = '0;
          out_req_nxt.kind         = kmsc_pkg::KIND_STEP;
          out_req_nxt.column_drive = cmd_r.drive;
          out_req_nxt.last         = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pos_r == kmsc_pkg::POS_W'(kmsc_pkg::NUM_MAPPED)) begin
          if (out_free) begin
            out_valid_nxt            = 1'b1;
            out_req_nxt              = '0;
            out_req_nxt.kind         = kmsc_pkg::KIND_COMPLETE;
            out_req_nxt.column_drive = cmd_r.drive;
            out_req_nxt.all_released = (cmd_r.keys == '0);
            out_req_nxt.last         = 1'b1;
            state_nxt                = ST_IDLE;
          end
        end else if (cmd_r.changed[bit_idx]) begin
          if (out_free) begin
            out_valid_nxt            = 1'b1;
            out_req_nxt              = '0;
            out_req_nxt.kind         = kmsc_pkg::KIND_EVENT;
            out_req_nxt.matrix_index = bit_idx;
            out_req_nxt.key_id       = kmsc_pkg::map_key(pos_r);
            out_req_nxt.pressed      = cmd_r.keys[bit_idx];
            pos_nxt                  = pos_r + 1'b1;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
    cmd_r     <= cmd_nxt;
    out_req_r <= out_req_nxt;
  end

  pos_range_a: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= kmsc_pkg::POS_W'(kmsc_pkg::NUM_MAPPED))
    else $error("scan position past the key map");
  pop_idle_a: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("queue popped while busy");
  hold_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_req_r))
    else $error("stalled result changed");

endmodule

// ===== rtl/keypad_matrix_scan_change_events_core.sv =====
// Top level of the 4x4 keypad matrix scanner with key change events.
//
// The scanner takes one request per column sample (op 0, active-low row lines for the
// current column) or a start command (op 1) that clears the column counter, the scan
// bitmap and the previous bitmap. The front end folds each sample into the bitmap in the
// cycle it is accepted and places one work entry in a short queue; the back end drains
// that queue into a registered result port. Column samples one through three and start
// commands give a single column step result carrying the next active-low column drive.
// The fourth sample closes the scan: the back end walks the nine mapped key positions,
// one per cycle unless an event waits on a stalled result, emits a key event for every
// position whose state changed, and finishes with a scan complete result that drives all
// columns and flags an empty bitmap. Every request's final result has last set. A column
// step passes through a queue pop and then a result load, and a scan end through a pop,
// the nine map positions and the completion; the back-end walk over the key map is the
// longest part. With QUEUE_DEPTH entries of buffering the input stalls only once the
// queue is full, so a new sample is taken while earlier results are still on the way out.
module keypad_matrix_scan_change_events_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmsc_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output kmsc_pkg::out_req_t out_req
);

  // Queue handshake between the two halves.
  logic           q_push, q_full, q_pop, q_empty;
  kmsc_pkg::cmd_t q_push_data, q_pop_data;

  // The front end owns the column counter and both bitmaps, so classification waits on the
  // result side only through a full queue.
  kmsc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req      (in_req),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  kmsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_pop_data)
  );

  // The back end holds one work entry at a time and owns the output register.
  kmsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // Key events are never the final result of a request and carry no column drive.
  event_fields_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.kind == kmsc_pkg::KIND_EVENT
      |-> !out_req.last && out_req.column_drive == '0 && !out_req.all_released)
    else $error("key event with non-event fields set");

  // A column step drives exactly one column low and always ends its request.
  step_drive_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.kind == kmsc_pkg::KIND_STEP
      |-> out_req.last && $countones(out_req.column_drive) == 7)
    else $error("column step with a bad drive pattern");

  // Scan completion releases all columns to the idle drive and ends its request.
  complete_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.kind == kmsc_pkg::KIND_COMPLETE
      |-> out_req.last && out_req.column_drive == kmsc_pkg::DRIVE_IDLE)
    else $error("scan complete with bad fields");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the 4x4 keypad matrix scanner with key change events.
`timescale 1ns / 1ps

module tb;

  // Key names for the dense key id carried by key events.
  typedef enum logic [2:0] {
    KID_F1, KID_F2, KID_F3, KID_UP, KID_DOWN, KID_LEFT, KID_RIGHT, KID_ENTER
  } key_t;

  // One queued request, with a flag that makes the sender wait until the
  // scanner has delivered every result still owed before presenting it.
  typedef struct packed {
    logic              drain_first;
    kmsc_pkg::in_req_t req;
  } pending_req_t;

  // Matrix positions that produce events, in ascending bit order, and the key
  // that sits at each of them.
  localparam logic [3:0] KEY_POS [kmsc_pkg::NUM_MAPPED] = '{
    4'd0, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd14, 4'd15
  };
  localparam key_t KEY_AT_POS [kmsc_pkg::NUM_MAPPED] = '{
    KID_F1, KID_DOWN, KID_F2, KID_RIGHT, KID_F3, KID_RIGHT, KID_UP, KID_ENTER, KID_LEFT
  };

  localparam int RANDOM_REQS  = 96;
  localparam int MAX_CYCLES   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  kmsc_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kmsc_pkg::out_req_t out_req;

  keypad_matrix_scan_change_events_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Requests waiting to be presented; the front entry is the one on the bus.
  pending_req_t       pending_reqs[$];
  // Results the scanner still owes, oldest first.
  kmsc_pkg::out_req_t owed_results[$];

  // Shadow copy of the scanner state: current column, bitmap being built and
  // the bitmap of the last completed scan.
  logic [1:0]  shadow_column = '0;
  logic [15:0] shadow_scan = '0;
  logic [15:0] shadow_prev = '0;

  int unsigned cycle_count = 0;
  int unsigned total_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned checked_results = 0;
  int unsigned seen_events = 0;
  int unsigned seen_scan_ends = 0;
  int unsigned error_count = 0;
  // Number of accepted requests the driver has already moved past.
  int unsigned driver_seen = 0;

  // Work out what the scanner must return for one accepted request and append
  // it to the owed results. A start command clears everything and points at
  // column 0. A sample lands in its own column's four bits; the fourth one
  // closes the scan, yields one event per changed mapped key and then a scan
  // complete result.
  task automatic predict_scan_step(input kmsc_pkg::in_req_t req);
    kmsc_pkg::out_req_t res;
    logic [15:0]        flipped;
    logic [3:0]         pos;
    if (req.op == kmsc_pkg::OP_START) begin
      shadow_column = '0;
      shadow_scan   = '0;
      shadow_prev   = '0;
      res = '0;
      res.kind         = kmsc_pkg::KIND_STEP;
      res.column_drive = kmsc_pkg::DRIVE_FIRST;
      res.last         = 1'b1;
      owed_results.push_back(res);
    end else begin
      // Row lines are active low, so a pressed key reads as a zero.
      shadow_scan[{shadow_column, 2'b00} +: 4] = ~req.row_lines;
      if (shadow_column != kmsc_pkg::LAST_COLUMN) begin
        shadow_column = shadow_column + 2'd1;
        res = '0;
        res.kind         = kmsc_pkg::KIND_STEP;
        res.column_drive = ~(8'd1 << shadow_column);
        res.last         = 1'b1;
        owed_results.push_back(res);
      end else begin
        flipped = shadow_prev ^ shadow_scan;
        for (int i = 0; i < kmsc_pkg::NUM_MAPPED; i++) begin
          pos = KEY_POS[i];
          if (flipped[pos]) begin
            res = '0;
            res.kind         = kmsc_pkg::KIND_EVENT;
            res.matrix_index = pos;
            res.key_id       = KEY_AT_POS[i];
            res.pressed      = shadow_scan[pos];
            owed_results.push_back(res);
          end
        end
        shadow_prev   = shadow_scan;
        shadow_column = '0;
        res = '0;
        res.kind         = kmsc_pkg::KIND_COMPLETE;
        res.column_drive = kmsc_pkg::DRIVE_IDLE;
        res.all_released = (shadow_scan == 16'h0000);
        res.last         = 1'b1;
        owed_results.push_back(res);
      end
    end
  endtask

  task automatic queue_req(input logic op, input logic [3:0] rows, input logic drain_first);
    pending_req_t p;
    p.drain_first   = drain_first;
    p.req.op        = op;
    p.req.row_lines = rows;
    pending_reqs.push_back(p);
    total_reqs++;
  endtask

  // Sampling side. Everything here looks at values that settled at the
  // previous falling edge, so the order of events within the rising edge does
  // not matter. The prediction runs before the result check; since results are
  // registered, a request can never be answered in the cycle it is accepted.
  always @(posedge clk) begin : monitor
    kmsc_pkg::out_req_t want;
    logic               bad;
    cycle_count++;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_scan_step(in_req);
        void'(pending_reqs.pop_front());
        accepted_reqs++;
      end
      if (out_valid && !out_stall) begin
        checked_results++;
        if (out_req.kind == kmsc_pkg::KIND_EVENT) seen_events++;
        if (out_req.kind == kmsc_pkg::KIND_COMPLETE) seen_scan_ends++;
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"cycle %0d: result with nothing owed: kind=%0d idx=%0d key=%0d",
                      " pr=%b drive=%h rel=%b last=%b"},
                     cycle_count, out_req.kind, out_req.matrix_index, out_req.key_id,
                     out_req.pressed, out_req.column_drive, out_req.all_released,
                     out_req.last);
        end else begin
          want = owed_results.pop_front();
          bad = (out_req.kind !== want.kind) ||
                (out_req.matrix_index !== want.matrix_index) ||
                (out_req.key_id !== want.key_id) ||
                (out_req.pressed !== want.pressed) ||
                (out_req.column_drive !== want.column_drive) ||
                (out_req.all_released !== want.all_released) ||
                (out_req.last !== want.last);
          if (bad) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display({"cycle %0d: expected kind=%0d idx=%0d key=%0d",
                        " pr=%b drive=%h rel=%b last=%b"},
                       cycle_count, want.kind, want.matrix_index, want.key_id,
                       want.pressed, want.column_drive, want.all_released, want.last);
              $display({"cycle %0d:      got kind=%0d idx=%0d key=%0d",
                        " pr=%b drive=%h rel=%b last=%b"},
                       cycle_count, out_req.kind, out_req.matrix_index, out_req.key_id,
                       out_req.pressed, out_req.column_drive, out_req.all_released,
                       out_req.last);
            end
          end
        end
      end
    end
  end

  // Driving side. Inputs move only at the falling edge. The run is split in
  // thirds by accepted requests: first the sender idles rarely and the
  // receiver often, then the other way round, then neither idles. A request
  // on the bus stays put until it is taken, whatever the stall does.
  always @(negedge clk) begin : driver
    int unsigned phase;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_off;
    if (rst_n) begin
      phase = (total_reqs == 0) ? 2 : (accepted_reqs * 3) / total_reqs;
      case (phase)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      if (!in_valid || accepted_reqs != driver_seen) begin
        driver_seen = accepted_reqs;
        hold_off = (pending_reqs.size() == 0) ||
                   (pending_reqs[0].drain_first && owed_results.size() != 0) ||
                   ($urandom_range(99, 0) < send_idle_pct);
        if (hold_off) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req   <= pending_reqs[0].req;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < MAX_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles with %0d requests and %0d results outstanding",
             cycle_count, pending_reqs.size(), owed_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] prior_rows [4];
    logic [3:0] rows;
    int unsigned pick;
    int unsigned random_start;

    for (int c = 0; c < 4; c++) prior_rows[c] = 4'hf;

    // Directed part. The first scan runs with no start command, so it relies
    // on the cleared state after reset and reports only F1 going down.
    queue_req(kmsc_pkg::OP_SAMPLE, 4'he, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'hf, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'hf, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'hf, 1'b0);
    // Start with its row lines all zero: they must be ignored. Then every key
    // goes down at once, the longest burst of events a scan can give.
    queue_req(kmsc_pkg::OP_START, 4'h0, 1'b0);
    for (int c = 0; c < 4; c++) queue_req(kmsc_pkg::OP_SAMPLE, 4'h0, 1'b0);
    // Everything released again: nine release events and an empty bitmap.
    for (int c = 0; c < 4; c++) queue_req(kmsc_pkg::OP_SAMPLE, 4'hf, 1'b0);
    // A start in the middle of a scan throws the half-built bitmap away.
    queue_req(kmsc_pkg::OP_SAMPLE, 4'h0, 1'b0);
    queue_req(kmsc_pkg::OP_START, 4'hf, 1'b0);
    // Only unmapped positions pressed: no events, but not all released.
    queue_req(kmsc_pkg::OP_SAMPLE, 4'h9, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'h6, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'h7, 1'b0);
    queue_req(kmsc_pkg::OP_SAMPLE, 4'hc, 1'b0);
    // Releasing them is equally silent, and the scan reports all released.
    for (int c = 0; c < 4; c++) queue_req(kmsc_pkg::OP_SAMPLE, 4'hf, 1'b0);
    // The sender waits for the scanner to drain before this start.
    queue_req(kmsc_pkg::OP_START, 4'h5, 1'b1);

    // Random part. Mostly whole scans, either fresh rows, a quiet keypad, or
    // the previous scan with an occasional single key flipped, which is what
    // a real keypad looks like. The rest is lone starts and stray requests
    // that knock the column count out of step. Every so often the sender
    // holds back until the scanner has drained.
    random_start = total_reqs;
    while (total_reqs - random_start < RANDOM_REQS) begin
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
        queue_req(kmsc_pkg::OP_START, 4'($urandom_range(15, 0)), 1'b0);
      end else if (pick == 1) begin
        queue_req(1'($urandom_range(1, 0)), 4'($urandom_range(15, 0)),
                  ((total_reqs % 37) == 36));
      end else begin
        for (int c = 0; c < 4; c++) begin
          if (pick < 6) begin
            rows = prior_rows[c];
            if ($urandom_range(3, 0) == 0) rows = rows ^ (4'd1 << $urandom_range(3, 0));
          end else if (pick < 8) begin
            rows = 4'hf;
          end else begin
            rows = 4'($urandom_range(15, 0));
          end
          prior_rows[c] = rows;
          queue_req(kmsc_pkg::OP_SAMPLE, rows, (c == 0) && ((total_reqs % 37) == 36));
        end
      end
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || owed_results.size() != 0) @(posedge clk);
    // Give a misbehaving scanner the chance to emit stray results.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests under three stall profiles and checked %0d results:",
             accepted_reqs, checked_results);
    $display("  %0d key events over %0d completed scans.", seen_events, seen_scan_ends);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kmsc_pkg.sv
rtl/kmsc_front.sv
rtl/kmsc_queue.sv
rtl/kmsc_back.sv
rtl/keypad_matrix_scan_change_events_core.sv
tb/sv/tb.sv
